>>> rtl/fyp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// Fisher-Yates permutation builder. No dependencies.
package fyp_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int IDX_W    = 10;
    localparam int LEN_W    = 11;
    localparam int WORD_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(WORD_W);

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);

    typedef struct packed {
        logic latch;
        logic decode;
        logic fill_wr;
        logic div_start;
        logic rd_pair;
        logic wr_cur;
        logic wr_swap;
        logic rd_pos;
        logic finish;
    } fyp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             step_ok;
        logic             read_ok;
        logic             len_zero;
        logic             fill_last;
        logic             div_done;
        logic             out_free;
    } fyp_sts_t;

endpackage

>>> rtl/fyp_mod_unit.sv
// Iterative restoring remainder unit: word mod divisor, one bit per cycle.
// Depends on fyp_pkg.
module fyp_mod_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fyp_pkg::WORD_W-1:0] dividend,
    input  logic [fyp_pkg::LEN_W-1:0]  divisor,
    output logic                      done,
    output logic [fyp_pkg::IDX_W-1:0]  remainder
);
    import fyp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [LEN_W-1:0]  dsr_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W:0]    trial;
    logic [LEN_W-1:0]  rem_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[WORD_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = LEN_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[IDX_W-1:0];

endmodule

>>> rtl/fyp_datapath.sv
// Datapath: index store, cursor, request latch, remainder unit and result register.
// Depends on fyp_pkg and fyp_mod_unit.
module fyp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fyp_pkg::fyp_cmd_t            cmd,
    output fyp_pkg::fyp_sts_t            sts,
    input  logic [fyp_pkg::LEN_W-1:0]    eff_len,
    input  logic [fyp_pkg::REQ_W-1:0]    req_type,
    input  logic [fyp_pkg::WORD_W-1:0]   random_word,
    input  logic [fyp_pkg::IDX_W-1:0]    read_position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fyp_pkg::IDX_W-1:0]    read_value,
    output logic                         shuffle_done,
    output logic [fyp_pkg::STATUS_W-1:0] status
);
    import fyp_pkg::*;

    logic [IDX_W-1:0]    store_mem [MAX_LEN];

    logic [REQ_W-1:0]    req_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    cursor_reg;
    logic                started_reg;
    logic [IDX_W-1:0]    fill_cnt_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                read_hit_reg;
    logic [IDX_W-1:0]    rd_a_reg;
    logic [IDX_W-1:0]    rd_b_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_value_reg;
    logic                out_done_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                step_ok;
    logic                read_ok;
    logic [STATUS_W-1:0] dec_status;
    logic                div_done;
    logic [IDX_W-1:0]    j_idx;
    logic [LEN_W-1:0]    divisor;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    wr_data;

    assign step_ok = started_reg && (cursor_reg != '0);
    assign read_ok = {1'b0, pos_reg} < eff_len;
    assign divisor = {1'b0, cursor_reg} + LEN_W'(1);

    always_comb
    begin
        case (req_reg)
            REQ_START: dec_status = ST_OK;
            REQ_STEP:  dec_status = step_ok ? ST_OK : ST_IGNORED;
            REQ_READ:  dec_status = read_ok ? ST_OK : ST_RANGE;
            default:   dec_status = ST_IGNORED;
        endcase
    end

    fyp_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (word_reg),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (j_idx)
    );

    // single write port: identity fill, then the two halves of a swap
    always_comb
    begin
        wr_en   = cmd.fill_wr || cmd.wr_cur || cmd.wr_swap;
        wr_addr = fill_cnt_reg;
        wr_data = fill_cnt_reg;
        if (cmd.wr_cur)
        begin
            wr_addr = cursor_reg;
            wr_data = rd_b_reg;
        end
        else if (cmd.wr_swap)
        begin
            wr_addr = j_idx;
            wr_data = rd_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_pair)
        begin
            rd_a_reg <= store_mem[cursor_reg];
            rd_b_reg <= store_mem[j_idx];
        end
        else if (cmd.rd_pos)
        begin
            rd_a_reg <= store_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= req_type;
            word_reg <= random_word;
            pos_reg  <= read_position;
        end
        if (cmd.decode)
        begin
            res_status_reg <= dec_status;
            read_hit_reg   <= (req_reg == REQ_READ) && read_ok;
        end
        if (cmd.finish)
        begin
            out_value_reg  <= read_hit_reg ? rd_a_reg : '0;
            out_done_reg   <= started_reg && (cursor_reg == '0);
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            started_reg   <= 1'b0;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode && (req_reg == REQ_START))
            begin
                cursor_reg   <= (eff_len == '0) ? '0 : IDX_W'(eff_len - LEN_W'(1));
                started_reg  <= 1'b1;
                fill_cnt_reg <= '0;
            end
            if (cmd.fill_wr)
            begin
                fill_cnt_reg <= fill_cnt_reg + IDX_W'(1);
            end
            if (cmd.wr_swap)
            begin
                cursor_reg <= cursor_reg - IDX_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.req       = req_reg;
        sts.step_ok   = step_ok;
        sts.read_ok   = read_ok;
        sts.len_zero  = (eff_len == '0);
        sts.fill_last = ({1'b0, fill_cnt_reg} == (eff_len - LEN_W'(1)));
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = out_value_reg;
    assign shuffle_done = out_done_reg;
    assign status       = out_status_reg;

endmodule

>>> rtl/fyp_ctrl.sv
// Controller state machine: sequences decode, fill, remainder, swap, read and delivery.
// Depends on fyp_pkg.
module fyp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fyp_pkg::fyp_sts_t sts,
    output fyp_pkg::fyp_cmd_t cmd
);
    import fyp_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_FILL      = 4'd2;
    localparam logic [3:0] S_DIV       = 4'd3;
    localparam logic [3:0] S_READ_PAIR = 4'd4;
    localparam logic [3:0] S_WR_CUR    = 4'd5;
    localparam logic [3:0] S_WR_SWAP   = 4'd6;
    localparam logic [3:0] S_READ_POS  = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (sts.req)
                    REQ_START: state_next = sts.len_zero ? S_FINISH : S_FILL;
                    REQ_STEP:
                    begin
                        cmd.div_start = sts.step_ok;
                        state_next    = sts.step_ok ? S_DIV : S_FINISH;
                    end
                    REQ_READ:  state_next = sts.read_ok ? S_READ_POS : S_FINISH;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_READ_PAIR;
                end
            end
            S_READ_PAIR:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = S_WR_CUR;
            end
            S_WR_CUR:
            begin
                cmd.wr_cur = 1'b1;
                state_next = S_WR_SWAP;
            end
            S_WR_SWAP:
            begin
                cmd.wr_swap = 1'b1;
                state_next  = S_FINISH;
            end
            S_READ_POS:
            begin
                cmd.rd_pos = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/fisher_yates_permutation_top.sv
// Top level of the Fisher-Yates permutation builder: APB register, controller, datapath.
// Depends on fyp_pkg, fyp_ctrl and fyp_datapath.
//
// Usage:
//   Request channel (in_valid/in_ready): req_type selects start (load the
//   identity into positions 0..L-1, L = min(list_length, 1024)), shuffle step
//   (swap the cursor entry with entry random_word mod (cursor+1), then drop the
//   cursor) or read (return entry read_position). One request is in flight at
//   a time; in_ready is high only while the block is idle.
//   Result channel (out_valid/out_ready): exactly one transaction per request,
//   carrying read_value, shuffle_done and status.
//   Order of work after a request is accepted: a start writes the identity
//   one store entry per cycle through the single write port; a step runs the
//   bit-serial remainder unit, then a two-entry read and two writes; a read
//   does one store read; an ignored or out-of-range request goes straight to
//   the result. The next request is accepted in the cycle after the result is
//   loaded.
//   A result waits in the output register while the receiver stalls; the
//   next request is accepted meanwhile and holds in its last state until
//   the output register frees.
//   Reset clears the cursor and the started flag and sets list_length to 1024;
//   the store is undefined until a start request fills it. The user must write
//   list_length through the APB port only while the block is idle; unchecked.
module fisher_yates_permutation_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fyp_pkg::REQ_W-1:0]    req_type,
    input  logic [fyp_pkg::WORD_W-1:0]   random_word,
    input  logic [fyp_pkg::IDX_W-1:0]    read_position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fyp_pkg::IDX_W-1:0]    read_value,
    output logic                         shuffle_done,
    output logic [fyp_pkg::STATUS_W-1:0] status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fyp_pkg::*;

    logic [LEN_W-1:0] list_length_reg;
    logic [LEN_W-1:0] eff_len;
    logic             reg_sel;
    fyp_cmd_t         cmd;
    fyp_sts_t         sts;

    // one register at byte address 0; bit 2 picks the word
    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= LEN_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            list_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = reg_sel ? {(32 - LEN_W)'(0), list_length_reg} : '0;

    // saturate the working length at the store depth
    assign eff_len = (list_length_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : list_length_reg;

    fyp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fyp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .eff_len       (eff_len),
        .req_type      (req_type),
        .random_word   (random_word),
        .read_position (read_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .shuffle_done  (shuffle_done),
        .status        (status)
    );

endmodule

>>> test/fyp_perm_checker.sv
// Result checker for the Fisher-Yates permutation builder: follows the request,
// result and APB channels, predicts each result and compares it field by field.
// Depends on fyp_pkg.
module fyp_perm_checker #(
    parameter logic [2:0] LEN_ADDR = 3'd0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [fyp_pkg::REQ_W-1:0]    req_type,
    input  logic [fyp_pkg::WORD_W-1:0]   random_word,
    input  logic [fyp_pkg::IDX_W-1:0]    read_position,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [fyp_pkg::IDX_W-1:0]    read_value,
    input  logic                         shuffle_done,
    input  logic [fyp_pkg::STATUS_W-1:0] status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    output int                           errors,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fyp_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]    value;
        logic                done;
        logic [STATUS_W-1:0] code;
    } perm_result_t;

    perm_result_t     pending_results[$];
    perm_result_t     oldest;
    logic [IDX_W-1:0] perm_shadow [MAX_LEN];
    logic [IDX_W-1:0] cursor_shadow;
    logic             started_shadow;
    logic [LEN_W-1:0] length_shadow;

    initial
    begin
        errors = 0;
        outstanding = 0;
        for (int k = 0; k < MAX_LEN; k++)
            perm_shadow[k] = '0;
    end

    // Lengths above the store depth saturate.
    function automatic int active_length();
        return (length_shadow > LEN_W'(MAX_LEN)) ? MAX_LEN : int'(length_shadow);
    endfunction

    function automatic perm_result_t predict_result(input logic [REQ_W-1:0]  req,
                                                    input logic [WORD_W-1:0] word,
                                                    input logic [IDX_W-1:0]  pos);
        perm_result_t      res;
        int                len;
        int                k;
        logic [WORD_W-1:0] divisor;
        logic [IDX_W-1:0]  j;
        logic [IDX_W-1:0]  swap_tmp;
        res = '0;
        len = active_length();
        case (req)
            REQ_START:
            begin
                for (k = 0; k < len; k++)
                    perm_shadow[k] = IDX_W'(k);
                cursor_shadow = (len > 0) ? IDX_W'(len - 1) : '0;
                started_shadow = 1'b1;
            end
            REQ_STEP:
            begin
                if (!started_shadow || cursor_shadow == '0)
                    res.code = ST_IGNORED;
                else
                begin
                    // plain modulo, bias and all
                    divisor = WORD_W'(cursor_shadow) + 1;
                    j = IDX_W'(word % divisor);
                    swap_tmp = perm_shadow[cursor_shadow];
                    perm_shadow[cursor_shadow] = perm_shadow[j];
                    perm_shadow[j] = swap_tmp;
                    cursor_shadow = cursor_shadow - 1'b1;
                end
            end
            REQ_READ:
            begin
                if (int'(pos) >= len)
                    res.code = ST_RANGE;
                else
                    res.value = perm_shadow[pos];
            end
            default:
                res.code = ST_IGNORED;
        endcase
        res.done = started_shadow && (cursor_shadow == '0);
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Retire results before taking the new request: a result can never belong
    // to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            cursor_shadow = '0;
            started_shadow = 1'b0;
            length_shadow = LEN_RESET;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
                length_shadow = pwdata[LEN_W-1:0];
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none outstanding: value %0d done %0d status %0d",
                             $time, read_value, shuffle_done, status);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("read_value", oldest.value, read_value);
                    check_field("shuffle_done", oldest.done, shuffle_done);
                    check_field("status", oldest.code, status);
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(predict_result(req_type, random_word, read_position));
        end
        outstanding = pending_results.size();
    end

endmodule

>>> test/fisher_yates_permutation_top_tb.sv
// Testbench top for the Fisher-Yates permutation builder: clock, reset, APB
// writes of list_length, request stimulus, result-side stalls and the verdict.
// Depends on fyp_pkg, fisher_yates_permutation_top and fyp_perm_checker.
module fisher_yates_permutation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fyp_pkg::*;

    // Request code 3 has no meaning in the block; it must come back ignored.
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam logic [2:0] LEN_ADDR = 3'd0;
    // Watchdog limit with plenty of margin over the slowest legal run.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1650;
    // Watch a little past the last result at the end for stray results.
    localparam int TAIL_CYCLES = 60;
    localparam int STEP_CAP = 48;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type;
    logic [WORD_W-1:0]   random_word;
    logic [IDX_W-1:0]    read_position;
    logic                out_valid;
    logic                out_ready;
    logic [IDX_W-1:0]    read_value;
    logic                shuffle_done;
    logic [STATUS_W-1:0] status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int send_idle = 25;
    int recv_idle = 78;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;

    // Stimulus-side view: the length last written and how much of the store
    // has been filled by some start (always a prefix 0..filled-1).
    logic [LEN_W-1:0] len_setting = LEN_RESET;
    int filled = 0;
    int rand_items = 0;

    always #6 clk = ~clk;

    fisher_yates_permutation_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .random_word   (random_word),
        .read_position (read_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .shuffle_done  (shuffle_done),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fyp_perm_checker #(
        .LEN_ADDR (LEN_ADDR)
    ) perm_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .random_word   (random_word),
        .read_position (read_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .shuffle_done  (shuffle_done),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** fisher_yates_permutation_top: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls at the current rate. A toggle of hold_req
    // asks for one long stall, counted here, so the block backs up and drops
    // in_ready while the sender keeps offering.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic int eff_len();
        return (len_setting > LEN_W'(MAX_LEN)) ? MAX_LEN : int'(len_setting);
    endfunction

    // Offer one transaction, starting and ending at a falling edge. Idle gaps
    // come before valid rises; once up, valid and payload hold until accepted.
    task automatic send_item(input logic [REQ_W-1:0] rq, input logic [WORD_W-1:0] w,
                             input logic [IDX_W-1:0] p, input bit counts);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        random_word <= w;
        read_position <= p;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (rq == REQ_START && eff_len() > filled)
            filled = eff_len();
        if (counts)
            rand_items++;
    endtask

    // Mostly random words, now and then the extremes and tiny values.
    task automatic send_step(input bit counts);
        int unsigned pick;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            w = '0;
        else if (pick == 1)
            w = '1;
        else if (pick == 2)
            w = WORD_W'($urandom_range(0, 15));
        else
            w = $urandom;
        send_item(REQ_STEP, w, IDX_W'($urandom), counts);
    endtask

    // Read only entries some start has written; anything at or past the
    // active length is fair game since it comes back out of range.
    task automatic send_read(input bit counts);
        int e;
        int lim;
        e = eff_len();
        lim = (filled < e) ? filled : e;
        if (lim > 0 && ($urandom_range(0, 9) < 8 || e >= MAX_LEN))
            send_item(REQ_READ, $urandom, IDX_W'($urandom_range(0, lim - 1)), counts);
        else if (e < MAX_LEN)
            send_item(REQ_READ, $urandom, IDX_W'($urandom_range(e, MAX_LEN - 1)), counts);
        else
            send_item(REQ_NONE, $urandom, IDX_W'($urandom), counts);
    endtask

    // Drop valid and wait until every result is back and the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0 || !in_ready);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_length(input logic [LEN_W-1:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LEN_ADDR;
        pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        len_setting = v;
    endtask

    initial
    begin
        int unsigned pick;
        int phase_idx;
        int goal;
        int steps;
        int e;
        bit fresh;
        bit restarted;
        bit pressure;
        logic [LEN_W-1:0] new_len;

        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_START;
        random_word = '0;
        read_position = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = LEN_ADDR;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: step at reset state, empty and one-entry lists, reads
        // before any start, the unused request code.
        send_step(1'b0);
        write_length(LEN_W'(0));
        send_item(REQ_READ, '0, IDX_W'(0), 1'b0);
        send_item(REQ_READ, '1, IDX_W'(MAX_LEN - 1), 1'b0);
        send_item(REQ_NONE, '1, '1, 1'b0);
        send_item(REQ_START, '0, '0, 1'b0);
        send_item(REQ_STEP, '1, '0, 1'b0);
        write_length(LEN_W'(1));
        send_item(REQ_START, '0, '0, 1'b0);
        send_item(REQ_READ, '0, IDX_W'(0), 1'b0);
        send_item(REQ_STEP, 32'h1234_5678, '0, 1'b0);

        // Oversized length saturates at the store depth; extreme words, full
        // range reads, and a restart while a shuffle is under way.
        write_length('1);
        send_item(REQ_START, '0, '0, 1'b0);
        send_item(REQ_READ, '0, IDX_W'(MAX_LEN - 1), 1'b0);
        send_item(REQ_STEP, '1, '0, 1'b0);
        send_item(REQ_STEP, '0, '0, 1'b0);
        send_item(REQ_READ, '0, IDX_W'(MAX_LEN - 1), 1'b0);
        send_item(REQ_READ, '0, IDX_W'(0), 1'b0);
        send_item(REQ_START, '0, '0, 1'b0);
        send_step(1'b0);

        // Shrink the length mid-shuffle: the cursor carries on from the top.
        write_length(LEN_W'(4));
        send_step(1'b0);
        send_item(REQ_READ, '0, IDX_W'(3), 1'b0);
        send_item(REQ_READ, '0, IDX_W'(4), 1'b0);
        send_item(REQ_START, '0, '0, 1'b0);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);

        // Random phases: each writes a new length, then mostly runs a full
        // shuffle (start, steps until done) with reads mixed in. Some phases
        // skip the start to carry the old cursor over a length change.
        phase_idx = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (rand_items < RANDOM_ITEMS / 3)
            begin
                send_idle = 25;
                recv_idle = 78;
            end
            else if (rand_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 78;
                recv_idle = 25;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end

            pressure = (phase_idx % 25 == 4);
            pick = $urandom_range(0, 99);
            if (pressure)
                new_len = LEN_W'(30);
            else if (pick < 5)
                new_len = LEN_W'($urandom_range(0, 1));
            else if (pick < 9)
                new_len = LEN_W'($urandom_range(41, MAX_LEN));
            else if (pick < 11)
                new_len = LEN_W'($urandom_range(MAX_LEN + 1, 2 ** LEN_W - 1));
            else
                new_len = LEN_W'($urandom_range(2, 40));
            write_length(new_len);

            fresh = pressure || ($urandom_range(0, 3) != 0);
            if (fresh)
                send_item(REQ_START, $urandom, IDX_W'($urandom), 1'b1);
            if (pressure)
                hold_req = ~hold_req;

            // Large lists only get a partial shuffle to keep the run short.
            e = eff_len();
            goal = (e > 1) ? e - 1 : 1;
            if (goal > STEP_CAP)
                goal = STEP_CAP;
            steps = 0;
            restarted = 1'b0;
            while (steps < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                begin
                    send_step(1'b1);
                    steps++;
                end
                else if (pick < 90)
                    send_read(1'b1);
                else if (pick < 93 && fresh && !restarted)
                begin
                    send_item(REQ_START, $urandom, IDX_W'($urandom), 1'b1);
                    restarted = 1'b1;
                    steps = 0;
                end
                else
                    send_item(REQ_NONE, $urandom, IDX_W'($urandom), 1'b1);
            end
            // one more step, past done when the shuffle ran to the end, then a look at the result
            send_step(1'b1);
            send_read(1'b1);
            phase_idx++;
        end

        // Let everything drain, then watch a while longer for stray results.
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("** fisher_yates_permutation_top: PASSED **");
        else
            $display("** fisher_yates_permutation_top: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/fyp_pkg.sv
rtl/fyp_mod_unit.sv
rtl/fyp_datapath.sv
rtl/fyp_ctrl.sv
rtl/fisher_yates_permutation_top.sv
test/fyp_perm_checker.sv
test/fisher_yates_permutation_top_tb.sv
